### rtl/dmxrx_pkg.sv
// ============================================================================
// dmxrx_pkg: shared types and constants of the DMX512 slot receiver
// Holds the channel count, field widths, state codes and the result record.
// ============================================================================
package dmxrx_pkg;

	localparam int CHANNELS   = 16;
	localparam int CH_IDX_W   = 4;
	localparam int BYTE_W     = 8;
	localparam int ADDR_W     = 10;
	localparam int SLOT_W     = 9;
	localparam int STATE_W    = 2;
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;

	localparam logic [ADDR_W-1:0] ADDR_RESET = ADDR_W'(1);
	localparam logic [ADDR_W-1:0] ADDR_MAX   = ADDR_W'(512);

	// Register index, taken from paddr[2].
	localparam logic REG_START_ADDRESS = 1'b0;

	// Codes reported in the rx_state field.
	localparam logic [STATE_W-1:0] RX_STATE_IDLE  = 2'd0;
	localparam logic [STATE_W-1:0] RX_STATE_BREAK = 2'd1;
	localparam logic [STATE_W-1:0] RX_STATE_SKIP  = 2'd2;
	localparam logic [STATE_W-1:0] RX_STATE_DATA  = 2'd3;

	typedef enum logic [3:0] {
		MODE_IDLE  = 4'b0001,
		MODE_BREAK = 4'b0010,
		MODE_SKIP  = 4'b0100,
		MODE_DATA  = 4'b1000
	} mode_t;

	typedef struct packed {
		logic [STATE_W-1:0]  rx_state;
		logic                captured;
		logic [CH_IDX_W-1:0] channel_index;
		logic [BYTE_W-1:0]   channel_value;
		logic                value_changed;
		logic [CHANNELS-1:0] changed_mask;
	} result_t;

	function automatic logic [STATE_W-1:0] mode_code(input mode_t m);
		logic [STATE_W-1:0] c;
		unique case (m)
			MODE_IDLE:  c = RX_STATE_IDLE;
			MODE_BREAK: c = RX_STATE_BREAK;
			MODE_SKIP:  c = RX_STATE_SKIP;
			MODE_DATA:  c = RX_STATE_DATA;
			default:    c = RX_STATE_IDLE;
		endcase
		return c;
	endfunction

endpackage

### rtl/dmxrx_if.sv
// ============================================================================
// dmxrx_if: valid/ready channels of the DMX512 slot receiver
// One interface for received bytes and one for result beats.
// ============================================================================
interface dmxrx_in_if import dmxrx_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;
	logic              frame_error;
	logic              overrun;

	modport source (output valid, output rx_byte, output frame_error, output overrun,
		input ready);
	modport sink (input valid, input rx_byte, input frame_error, input overrun,
		output ready);
endinterface

interface dmxrx_out_if import dmxrx_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATE_W-1:0]  rx_state;
	logic                captured;
	logic [CH_IDX_W-1:0] channel_index;
	logic [BYTE_W-1:0]   channel_value;
	logic                value_changed;
	logic [CHANNELS-1:0] changed_mask;

	modport source (output valid, output rx_state, output captured, output channel_index,
		output channel_value, output value_changed, output changed_mask, input ready);
	modport sink (input valid, input rx_state, input captured, input channel_index,
		input channel_value, input value_changed, input changed_mask, output ready);
endinterface

### rtl/dmxrx_apb.sv
// ============================================================================
// dmxrx_apb: configuration register port
// Holds the start address register behind a simple APB-style slave.
// ============================================================================
module dmxrx_apb import dmxrx_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output logic [ADDR_W-1:0]  start_address
);

	logic [ADDR_W-1:0] start_q;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= ADDR_RESET;
		end else if (wr_en && (paddr[2] == REG_START_ADDRESS)) begin
			start_q <= pwdata[ADDR_W-1:0];
		end
	end

	always_comb begin
		if (paddr[2] == REG_START_ADDRESS) begin
			prdata = {{(PDATA_W-ADDR_W){1'b0}}, start_q};
		end else begin
			prdata = '0;
		end
	end

	assign start_address = start_q;

endmodule

### rtl/dmxrx_core.sv
// ============================================================================
// dmxrx_core: slot decoder and channel store
// Steps the receive state for one byte and forms its result record.
// ============================================================================
module dmxrx_core import dmxrx_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [ADDR_W-1:0] start_address,
	input  logic [BYTE_W-1:0] rx_byte,
	input  logic              frame_error,
	input  logic              overrun,
	output result_t           res
);

	mode_t               mode_q, mode_d;
	logic [SLOT_W-1:0]   slot_q, slot_d;
	logic [BYTE_W-1:0]   store_q [CHANNELS];
	logic [CHANNELS-1:0] change_q, change_d;
	logic [ADDR_W-1:0]   eff_addr;
	logic [ADDR_W-1:0]   addr_m1;
	logic [ADDR_W:0]     slot_inc;
	logic [CH_IDX_W-1:0] idx;
	logic                wr_store;

	// Out-of-range start addresses are clamped into 1..512.
	always_comb begin
		if (start_address == '0) begin
			eff_addr = ADDR_W'(1);
		end else if (start_address > ADDR_MAX) begin
			eff_addr = ADDR_MAX;
		end else begin
			eff_addr = start_address;
		end
	end

	assign addr_m1  = eff_addr - ADDR_W'(1);
	assign slot_inc = {2'b00, slot_q} + (ADDR_W+1)'(1);
	assign idx      = slot_q[CH_IDX_W-1:0];

	always_comb begin
		mode_d   = mode_q;
		slot_d   = slot_q;
		change_d = change_q;
		wr_store = 1'b0;
		res      = '0;
		if (frame_error || overrun) begin
			mode_d = MODE_BREAK;
		end else begin
			unique case (mode_q)
				MODE_BREAK: begin
					if (rx_byte != '0) begin
						mode_d = MODE_IDLE;
					end else begin
						slot_d = addr_m1[SLOT_W-1:0];
						mode_d = (addr_m1[SLOT_W-1:0] == '0) ? MODE_DATA : MODE_SKIP;
					end
				end
				MODE_SKIP: begin
					slot_d = slot_q - SLOT_W'(1);
					if (slot_d == '0) mode_d = MODE_DATA;
				end
				MODE_DATA: begin
					res.captured      = 1'b1;
					res.channel_index = idx;
					res.channel_value = rx_byte;
					if (store_q[idx] != rx_byte) begin
						wr_store            = 1'b1;
						change_d[idx]       = 1'b1;
						res.value_changed   = 1'b1;
					end
					slot_d = slot_inc[SLOT_W-1:0];
					if (slot_inc >= (ADDR_W+1)'(CHANNELS)) mode_d = MODE_IDLE;
				end
				default: begin
				end
			endcase
		end
		res.rx_state     = mode_code(mode_d);
		res.changed_mask = change_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			slot_q   <= '0;
			change_q <= '0;
			for (int i = 0; i < CHANNELS; i++) store_q[i] <= '0;
		end else if (step) begin
			mode_q   <= mode_d;
			slot_q   <= slot_d;
			change_q <= change_d;
			if (wr_store) store_q[idx] <= rx_byte;
		end
	end

	// Changed bits are sticky: once set, only reset clears them.
	a_mask_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		1 |=> ((change_q & $past(change_q)) == $past(change_q)))
		else $error("changed mask lost a bit");

	a_data_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_DATA) |-> (slot_q < SLOT_W'(CHANNELS)))
		else $error("slot count beyond channel range in data state");

	a_skip_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_SKIP) |-> (slot_q != '0))
		else $error("skip state with nothing left to skip");

	a_store_write: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res.value_changed) |=>
		(store_q[$past(res.channel_index)] == $past(res.channel_value)))
		else $error("changed value not written to channel store");

endmodule

### rtl/dmx512_slot_receiver_top.sv
// ============================================================================
// dmx512_slot_receiver_top: DMX512 slot receiver
// Decodes breaks, start codes and slots, and captures a block of channels.
// ============================================================================
//  channel   dir  handshake              payload
//  in_ch     in   valid/ready            rx_byte, frame_error, overrun
//  out_ch    out  valid/ready            rx_state, captured, channel_index,
//                                        channel_value, value_changed, changed_mask
//  apb       in   psel/penable, pready=1 start_address at byte address 0
//
// Each byte gives one result beat via the input, then the output register; one byte
// is taken each cycle unless the output stalls, paced by the slot decoder's step.
// The input register refills while a result waits in the output register.
// Reset is asynchronous; it clears the state, the channel store and the mask.
// A stalled output holds its beat and stops intake once the input register is full.
// ============================================================================
module dmx512_slot_receiver_top import dmxrx_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	dmxrx_in_if.sink           in_ch,
	dmxrx_out_if.source        out_ch,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              fe_s1;
	logic              ovr_s1;
	logic              out_valid_q;
	result_t           res_d;
	result_t           res_q;
	logic              adv;
	logic              take;
	logic [ADDR_W-1:0] start_address;

	dmxrx_apb u_apb (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.start_address (start_address)
	);

	dmxrx_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (adv),
		.start_address (start_address),
		.rx_byte       (byte_s1),
		.frame_error   (fe_s1),
		.overrun       (ovr_s1),
		.res           (res_d)
	);

	// The staged byte moves on whenever the output register is free or drains.
	assign adv         = valid_s1 & (~out_valid_q | out_ch.ready);
	assign in_ch.ready = ~valid_s1 | adv;
	assign take        = in_ch.valid & in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= in_ch.rx_byte;
			fe_s1   <= in_ch.frame_error;
			ovr_s1  <= in_ch.overrun;
		end
		if (adv) res_q <= res_d;
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.rx_state      = res_q.rx_state;
	assign out_ch.captured      = res_q.captured;
	assign out_ch.channel_index = res_q.channel_index;
	assign out_ch.channel_value = res_q.channel_value;
	assign out_ch.value_changed = res_q.value_changed;
	assign out_ch.changed_mask  = res_q.changed_mask;

endmodule
